// ===== src/ifr_pkg.sv =====
// ----------------------------------------------------------------------------
// ifr_pkg: shared definitions for the information frame receiver
// Line codes, frame limits, reply codes and the result record.
// ----------------------------------------------------------------------------
package ifr_pkg;

  // Largest frame on the line, header and trailer included (range 16..65536)
  localparam int unsigned MAX_FRAME_BYTES = 512;

  // Payload bytes a frame may deliver: header, BCC1, BCC2 and the two flags
  // take six, and the count field caps it at 511.
  localparam int unsigned PAYLOAD_LIMIT_INT =
    ((MAX_FRAME_BYTES - 6) > 511) ? 511 : (MAX_FRAME_BYTES - 6);
  localparam logic [8:0] PAYLOAD_LIMIT = 9'(PAYLOAD_LIMIT_INT);

  localparam logic [7:0] FLAG_BYTE      = 8'h7E;
  localparam logic [7:0] ESC_BYTE       = 8'h7D;
  localparam logic [7:0] STUFF_MASK     = 8'h20;
  localparam logic [7:0] CTRL_I0        = 8'h00;
  localparam logic [7:0] CTRL_I1        = 8'h40;
  localparam logic [7:0] ADDRESS_RESET  = 8'h03;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  typedef enum logic [1:0] {
    REPLY_RR0  = 2'd0,
    REPLY_RR1  = 2'd1,
    REPLY_REJ0 = 2'd2,
    REPLY_REJ1 = 2'd3
  } reply_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] payload_byte;
    logic       frame_good;
    reply_t     reply_code;
    logic [8:0] payload_count;
  } result_t;

endpackage

// ===== src/info_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// info_frame_receiver: HDLC-like information frame receiver
// Flag hunt, address/control/BCC1 header check, byte destuffing, running
// XOR for BCC2 and a supervisory reply verdict at the closing flag.
// ----------------------------------------------------------------------------
// Each result is formed combinationally from its request and registered in the output register.
// Throughput: one line byte per cycle while rx_stall is low; the per-byte logic
//   sits in a single stage between the state registers and the result register.
// A one-entry skid stage behind the result register keeps rx requests
//   flowing while a result waits; rx_stall rises only when both are full.
// Reset (rst, synchronous): hunting for a flag, no result, address 0x03.
// ----------------------------------------------------------------------------
module info_frame_receiver (
  input  logic       clk,
  input  logic       rst,
  // configuration
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  // line byte channel
  input  logic       rx_valid,
  output logic       rx_stall,
  input  logic [7:0] rx_byte,
  // result channel
  output logic       res_valid,
  input  logic       res_stall,
  output logic       kind,
  output logic [7:0] payload_byte,
  output logic       frame_good,
  output logic [1:0] reply_code,
  output logic [8:0] payload_count
);

  typedef enum logic [2:0] {
    PH_HUNT,   // waiting for an opening flag
    PH_FLAG,   // flag seen, expecting the address
    PH_ADDR,   // address matched, expecting control
    PH_CTRL,   // control kept, expecting BCC1
    PH_DATA    // inside the information field
  } phase_t;

  // Registers
  logic [7:0]      expected_address;
  phase_t          phase, phase_next;
  logic [7:0]      control_byte, control_byte_next;
  logic            escape_pending, escape_pending_next;
  logic [7:0]      held_byte, held_byte_next;
  logic            held_valid, held_valid_next;
  logic [7:0]      running_xor, running_xor_next;
  logic [8:0]      byte_count, byte_count_next;
  logic            overflowed, overflowed_next;

  // Output register and skid stage
  logic            out_valid;
  ifr_pkg::result_t out_res;
  logic            skid_valid;
  ifr_pkg::result_t skid_res;

  // Per-byte result from the combinational stage
  logic            gen_valid;
  ifr_pkg::result_t gen_res;

  logic            rx_take;
  logic            res_take;
  logic            is_info;
  logic            good;
  logic [7:0]      data_byte;

  assign rx_stall = skid_valid;
  assign rx_take  = rx_valid && !rx_stall;
  assign res_take = out_valid && !res_stall;

  assign is_info = (control_byte == ifr_pkg::CTRL_I0) ||
                   (control_byte == ifr_pkg::CTRL_I1);
  assign good    = held_valid && !escape_pending && !overflowed &&
                   (held_byte == running_xor);
  // An escaped byte is restored by flipping bit 5
  assign data_byte = escape_pending ? (rx_byte ^ ifr_pkg::STUFF_MASK) : rx_byte;

  // --------------------------------------------------------------------------
  // Frame machine: next state and the result (if any) of the current byte
  // --------------------------------------------------------------------------
  always_comb begin
    phase_next          = phase;
    control_byte_next   = control_byte;
    escape_pending_next = escape_pending;
    held_byte_next      = held_byte;
    held_valid_next     = held_valid;
    running_xor_next    = running_xor;
    byte_count_next     = byte_count;
    overflowed_next     = overflowed;
    gen_valid           = 1'b0;
    gen_res             = '0;

    if (rx_take) begin
      unique case (phase)
        PH_HUNT: begin
          if (rx_byte == ifr_pkg::FLAG_BYTE) phase_next = PH_FLAG;
        end
        PH_FLAG: begin
          if (rx_byte == expected_address) phase_next = PH_ADDR;
          else if (rx_byte != ifr_pkg::FLAG_BYTE) phase_next = PH_HUNT;
        end
        PH_ADDR: begin
          if (rx_byte == ifr_pkg::FLAG_BYTE) begin
            phase_next = PH_FLAG;
          end else begin
            control_byte_next = rx_byte;
            phase_next        = PH_CTRL;
          end
        end
        PH_CTRL: begin
          // a BCC1 match wins even when the byte looks like a flag
          if (rx_byte == (expected_address ^ control_byte)) begin
            phase_next          = PH_DATA;
            escape_pending_next = 1'b0;
            held_byte_next      = '0;
            held_valid_next     = 1'b0;
            running_xor_next    = '0;
            byte_count_next     = '0;
            overflowed_next     = 1'b0;
          end else if (rx_byte == ifr_pkg::FLAG_BYTE) begin
            phase_next = PH_FLAG;
          end else begin
            phase_next = PH_HUNT;
          end
        end
        PH_DATA: begin
          if (rx_byte == ifr_pkg::FLAG_BYTE) begin
            // closing flag: the held byte is BCC2
            gen_valid             = 1'b1;
            gen_res.kind          = ifr_pkg::KIND_VERDICT;
            gen_res.frame_good    = good;
            gen_res.payload_count = byte_count;
            if (control_byte == ifr_pkg::CTRL_I1)
              gen_res.reply_code = good ? ifr_pkg::REPLY_RR0 : ifr_pkg::REPLY_REJ0;
            else
              gen_res.reply_code = good ? ifr_pkg::REPLY_RR1 : ifr_pkg::REPLY_REJ1;
            phase_next = PH_HUNT;
          end else if (is_info) begin
            if (!escape_pending && rx_byte == ifr_pkg::ESC_BYTE) begin
              escape_pending_next = 1'b1;
            end else begin
              escape_pending_next = 1'b0;
              if (held_valid) begin
                if (byte_count >= ifr_pkg::PAYLOAD_LIMIT) begin
                  overflowed_next = 1'b1;
                end else begin
                  byte_count_next       = byte_count + 9'd1;
                  running_xor_next      = running_xor ^ held_byte;
                  gen_valid             = 1'b1;
                  gen_res.kind          = ifr_pkg::KIND_PAYLOAD;
                  gen_res.payload_byte  = held_byte;
                  gen_res.payload_count = byte_count + 9'd1;
                end
              end
              held_byte_next  = data_byte;
              held_valid_next = 1'b1;
            end
          end
        end
        default: phase_next = PH_HUNT;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // State, configuration and result registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_address <= ifr_pkg::ADDRESS_RESET;
      phase            <= PH_HUNT;
      control_byte     <= '0;
      escape_pending   <= 1'b0;
      held_byte        <= '0;
      held_valid       <= 1'b0;
      running_xor      <= '0;
      byte_count       <= '0;
      overflowed       <= 1'b0;
      out_valid        <= 1'b0;
      skid_valid       <= 1'b0;
    end else begin
      if (cfg_we) expected_address <= cfg_wdata;
      phase          <= phase_next;
      control_byte   <= control_byte_next;
      escape_pending <= escape_pending_next;
      held_byte      <= held_byte_next;
      held_valid     <= held_valid_next;
      running_xor    <= running_xor_next;
      byte_count     <= byte_count_next;
      overflowed     <= overflowed_next;

      // output register refills from the skid first, keeping order
      if (!out_valid || res_take) begin
        if (skid_valid) begin
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          out_valid <= gen_valid;
        end
      end else if (gen_valid) begin
        skid_valid <= 1'b1;
      end
    end
  end

  // payload of the result path, no reset needed
  always_ff @(posedge clk) begin
    if (!out_valid || res_take) begin
      if (skid_valid) out_res <= skid_res;
      else            out_res <= gen_res;
    end
    if (!skid_valid && out_valid && !res_take) skid_res <= gen_res;
  end

  assign res_valid     = out_valid;
  assign kind          = out_res.kind;
  assign payload_byte  = out_res.payload_byte;
  assign frame_good    = out_res.frame_good;
  assign reply_code    = out_res.reply_code;
  assign payload_count = out_res.payload_count;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // the skid stage only fills behind a waiting result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid stage holds a result with output register empty");

  // a good verdict always asks for a receiver-ready reply
  a_good_is_rr: assert property (@(posedge clk) disable iff (rst)
    (res_valid && kind == ifr_pkg::KIND_VERDICT && frame_good) |->
      (reply_code == ifr_pkg::REPLY_RR0 || reply_code == ifr_pkg::REPLY_RR1))
    else $error("good frame with a reject reply");

  // delivered payload bytes are counted from one up to the limit
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (res_valid && kind == ifr_pkg::KIND_PAYLOAD) |->
      (payload_count != 9'd0 && payload_count <= ifr_pkg::PAYLOAD_LIMIT))
    else $error("payload count out of range");

  // outside a frame's data field no result can be produced
  a_no_result_in_header: assert property (@(posedge clk) disable iff (rst)
    (phase != PH_DATA) |-> !gen_valid)
    else $error("result produced outside the information field");

endmodule
